>>> sv/set_assoc_lru_tag_cache_core_assert.svh
// ----------------------------------------------------------------------------
// set_assoc_lru_tag_cache_core_assert.svh
// Assertion macros shared by the checker of the cache tag lookup core.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_LRU_TAG_CACHE_CORE_ASSERT_SVH
`define SET_ASSOC_LRU_TAG_CACHE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define SALC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SALC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also checks through reset.
`define SALC_ASSERT_NXT_RAW(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/salc_pkg.sv
// ----------------------------------------------------------------------------
// salc_pkg
// Shared types and constants of the set-associative LRU tag lookup core.
// ----------------------------------------------------------------------------
package salc_pkg;

  localparam int ADDR_W      = 32;
  localparam int TAG_W       = 30;
  localparam int OUT_CNT_W   = 32;
  localparam int SET_OUT_W   = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 4;
  localparam int IB_W        = 4;
  localparam int BW_W        = 3;
  localparam int WAYS_CFG_W  = 4;
  localparam int MAX_BLK_LOG2 = 4;
  localparam int BYTE_OFS_W  = 2;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LOG2  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE = 2'd2;

  // Register reset values
  localparam logic [IB_W-1:0]       RST_INDEX_BITS  = 4'd4;
  localparam logic [BW_W-1:0]       RST_BLOCK_LOG2  = 3'd0;
  localparam logic [WAYS_CFG_W-1:0] RST_WAYS_IN_USE = 4'd1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } salc_state_t;

endpackage

>>> sv/salc_ram.sv
// ----------------------------------------------------------------------------
// salc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/salc_set_update.sv
// ----------------------------------------------------------------------------
// salc_set_update
// Tag compare over one set row and the LRU reorder of that row.
// ----------------------------------------------------------------------------
module salc_set_update
  import salc_pkg::*;
#(
  parameter int MAX_WAYS = 8,
  parameter int WAYS_W   = 4
) (
  input  logic [WAYS_W-1:0]               ways,
  input  logic [TAG_W-1:0]                tag,
  input  logic [MAX_WAYS-1:0][TAG_W-1:0]  row_tags,
  input  logic [MAX_WAYS-1:0]             row_valid,
  output logic                            hit,
  output logic [MAX_WAYS-1:0][TAG_W-1:0]  new_tags,
  output logic [MAX_WAYS-1:0]             new_valid
);

  localparam int POS_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

  logic [MAX_WAYS-1:0] hit_vec;
  logic [POS_W-1:0]    pos;
  logic [WAYS_W-1:0]   shift_from;

  // compare every way in use, gated by its valid bit
  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      hit_vec[i] = row_valid[i] && (row_tags[i] == tag) && (WAYS_W'(i) < ways);
    end
  end

  // pick the lowest matching position
  always_comb begin
    hit = 1'b0;
    pos = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit = 1'b1;
        pos = POS_W'(i);
      end
    end
  end

  // a miss drops the LRU position, so it shifts from the bottom
  assign shift_from = hit ? WAYS_W'(pos) : '0;

  // shift the entries above the vacated position down, new MRU on top
  for (genvar g = 0; g < MAX_WAYS; g++) begin : g_way
    logic in_use;
    logic is_top;
    assign in_use = WAYS_W'(g) < ways;
    assign is_top = WAYS_W'(g + 1) == ways;

    if (g < MAX_WAYS - 1) begin : g_shift
      logic do_shift;
      assign do_shift = in_use && !is_top && (WAYS_W'(g) >= shift_from);
      always_comb begin
        if (is_top) begin
          new_tags[g]  = tag;
          new_valid[g] = 1'b1;
        end else if (do_shift) begin
          new_tags[g]  = row_tags[g+1];
          new_valid[g] = row_valid[g+1];
        end else begin
          new_tags[g]  = row_tags[g];
          new_valid[g] = row_valid[g];
        end
      end
    end else begin : g_last
      always_comb begin
        if (is_top) begin
          new_tags[g]  = tag;
          new_valid[g] = 1'b1;
        end else begin
          new_tags[g]  = row_tags[g];
          new_valid[g] = row_valid[g];
        end
      end
    end
  end

endmodule

>>> sv/set_assoc_lru_tag_cache_core.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_tag_cache_core
// Set-associative tag lookup with true LRU order and running access counts.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall/in_address) takes one byte address per
//   beat. The result channel (out_valid/out_stall/out_*) returns one beat per
//   address: hit flag, set index and wrapping access, hit and miss counts.
//   Configuration (cfg_wr_en/cfg_index/cfg_data) writes index_bits,
//   block_words_log2 and ways_in_use; write only while the core is idle.
// Timing:
//   A beat accepted in ST_IDLE reads its set row from the set RAM; in ST_LOOKUP
//   the row is compared, reordered and written back and the result registered,
//   once the output register is free. The next address waits for that
//   write-back, as the read and the write-back share the single set RAM port pair.
// Reset:
//   Synchronous, active low. Counters and configuration return to their
//   reset values, then a clearing pass writes every set row invalid, one row
//   per cycle, 2**MAX_INDEX_BITS rows (256 by default); in_stall stays high.
// Stall:
//   A pending result holds in the output register while out_stall is high; a
//   new address may be accepted meanwhile, but its write-back waits until the
//   output register is free.
// ----------------------------------------------------------------------------
module set_assoc_lru_tag_cache_core
  import salc_pkg::*;
#(
  parameter int MAX_INDEX_BITS = 8,
  parameter int MAX_WAYS       = 8,
  parameter int COUNT_WIDTH    = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // address beats
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [ADDR_W-1:0]     in_address,
  // result beats
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_hit,
  output logic [SET_OUT_W-1:0]  out_set_index,
  output logic [OUT_CNT_W-1:0]  out_access_count,
  output logic [OUT_CNT_W-1:0]  out_hit_count,
  output logic [OUT_CNT_W-1:0]  out_miss_count
);

  localparam int SET_W  = MAX_INDEX_BITS;
  localparam int SETS   = 1 << MAX_INDEX_BITS;
  localparam int WAYS_W = $clog2(MAX_WAYS + 1);
  localparam int ROW_W  = MAX_WAYS * (TAG_W + 1);
  localparam int EXT_W  = (COUNT_WIDTH > OUT_CNT_W) ? COUNT_WIDTH : OUT_CNT_W;

  // configuration registers
  logic [IB_W-1:0]       cfg_index_bits_r;
  logic [BW_W-1:0]       cfg_block_log2_r;
  logic [WAYS_CFG_W-1:0] cfg_ways_r;

  // control
  salc_state_t       state_r, state_nxt;
  logic [SET_W-1:0]  clr_cnt_r;
  logic              out_valid_r, out_valid_nxt;
  logic              in_fire;
  logic              commit;
  logic              clr_we;

  // effective configuration
  logic [IB_W-1:0]   eff_ib;
  logic [BW_W-1:0]   eff_blk;
  logic [BW_W-1:0]   eff_ob;
  logic [WAYS_W-1:0] eff_ways;

  // address split
  logic [ADDR_W-1:0] shifted;
  logic [SET_W-1:0]  set_mask;
  logic [SET_W-1:0]  set_in;
  logic [TAG_W-1:0]  tag_in;
  logic [SET_W-1:0]  set_r;
  logic [TAG_W-1:0]  tag_r;

  // set RAM
  logic                           ram_we;
  logic [SET_W-1:0]               ram_waddr;
  logic [ROW_W-1:0]               ram_wdata;
  logic [ROW_W-1:0]               ram_rdata;
  logic [MAX_WAYS-1:0][TAG_W-1:0] row_tags, new_tags;
  logic [MAX_WAYS-1:0]            row_valid, new_valid;
  logic                           lk_hit;

  // counters
  logic [COUNT_WIDTH-1:0] acc_r, acc_nxt;
  logic [COUNT_WIDTH-1:0] hit_r, hit_nxt;
  logic [COUNT_WIDTH-1:0] miss_r, miss_nxt;
  logic [EXT_W-1:0]       acc_ext, hit_ext, miss_ext;

  // output payload registers
  logic                 out_hit_r;
  logic [SET_OUT_W-1:0] out_set_r;
  logic [OUT_CNT_W-1:0] out_acc_r, out_hitc_r, out_missc_r;

  // configuration writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_index_bits_r <= RST_INDEX_BITS;
      cfg_block_log2_r <= RST_BLOCK_LOG2;
      cfg_ways_r       <= RST_WAYS_IN_USE;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_INDEX_BITS:  cfg_index_bits_r <= cfg_data[IB_W-1:0];
        REG_BLOCK_LOG2:  cfg_block_log2_r <= cfg_data[BW_W-1:0];
        REG_WAYS_IN_USE: cfg_ways_r       <= cfg_data[WAYS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // saturate the configuration to what the store supports
  always_comb begin
    eff_ib  = (cfg_index_bits_r > IB_W'(MAX_INDEX_BITS)) ? IB_W'(MAX_INDEX_BITS)
                                                        : cfg_index_bits_r;
    eff_blk = (cfg_block_log2_r > BW_W'(MAX_BLK_LOG2)) ? BW_W'(MAX_BLK_LOG2)
                                                      : cfg_block_log2_r;
    eff_ob  = eff_blk + BW_W'(BYTE_OFS_W);
    if (cfg_ways_r == '0) begin
      eff_ways = WAYS_W'(1);
    end else if (5'(cfg_ways_r) > 5'(MAX_WAYS)) begin
      eff_ways = WAYS_W'(MAX_WAYS);
    end else begin
      eff_ways = WAYS_W'(cfg_ways_r);
    end
  end

  // split the address into set and tag
  assign shifted  = in_address >> eff_ob;
  assign set_mask = ~({SET_W{1'b1}} << eff_ib);
  assign set_in   = shifted[SET_W-1:0] & set_mask;
  assign tag_in   = TAG_W'(shifted >> eff_ib);

  assign in_stall = (state_r != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    commit    = 1'b0;
    clr_we    = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        clr_we = 1'b1;
        if (clr_cnt_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (!out_valid_r || !out_stall) begin
          commit    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      hit_r       <= '0;
      miss_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (clr_we) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (commit) begin
        acc_r  <= acc_nxt;
        hit_r  <= hit_nxt;
        miss_r <= miss_nxt;
      end
    end
  end

  // hold the split address for the lookup cycle
  always_ff @(posedge clk) begin
    if (in_fire) begin
      set_r <= set_in;
      tag_r <= tag_in;
    end
  end

  // set rows: {valid bits, tags}; the clearing pass writes them all invalid
  assign ram_we    = clr_we || commit;
  assign ram_waddr = clr_we ? clr_cnt_r : set_r;
  assign ram_wdata = clr_we ? '0 : {new_valid, new_tags};

  salc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_set_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_fire),
    .raddr (set_in),
    .rdata (ram_rdata)
  );

  assign {row_valid, row_tags} = ram_rdata;

  salc_set_update #(
    .MAX_WAYS (MAX_WAYS),
    .WAYS_W   (WAYS_W)
  ) u_set_update (
    .ways      (eff_ways),
    .tag       (tag_r),
    .row_tags  (row_tags),
    .row_valid (row_valid),
    .hit       (lk_hit),
    .new_tags  (new_tags),
    .new_valid (new_valid)
  );

  // advance the running counts
  assign acc_nxt  = acc_r + 1'b1;
  assign hit_nxt  = lk_hit ? hit_r + 1'b1 : hit_r;
  assign miss_nxt = lk_hit ? miss_r : miss_r + 1'b1;
  assign acc_ext  = EXT_W'(acc_nxt);
  assign hit_ext  = EXT_W'(hit_nxt);
  assign miss_ext = EXT_W'(miss_nxt);

  // load the result beat
  always_ff @(posedge clk) begin
    if (commit) begin
      out_hit_r   <= lk_hit;
      out_set_r   <= SET_OUT_W'(set_r);
      out_acc_r   <= acc_ext[OUT_CNT_W-1:0];
      out_hitc_r  <= hit_ext[OUT_CNT_W-1:0];
      out_missc_r <= miss_ext[OUT_CNT_W-1:0];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_set_index    = out_set_r;
  assign out_access_count = out_acc_r;
  assign out_hit_count    = out_hitc_r;
  assign out_miss_count   = out_missc_r;

endmodule

>>> sv/salc_checker.sv
// ----------------------------------------------------------------------------
// salc_checker
// Port-level checks of the cache tag lookup core, bound to its top level.
// ----------------------------------------------------------------------------
`include "set_assoc_lru_tag_cache_core_assert.svh"

module salc_checker
  import salc_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 out_hit,
  input logic [SET_OUT_W-1:0] out_set_index,
  input logic [OUT_CNT_W-1:0] out_access_count,
  input logic [OUT_CNT_W-1:0] out_hit_count,
  input logic [OUT_CNT_W-1:0] out_miss_count
);

  localparam int CHK_W = (COUNT_WIDTH < OUT_CNT_W) ? COUNT_WIDTH : OUT_CNT_W;

  logic             out_fire;
  logic             seen_r;
  logic [CHK_W-1:0] prev_acc_r;
  logic [CHK_W-1:0] prev_hit_r;

  assign out_fire = out_valid && !out_stall;

  // track the counts of the last delivered beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else if (out_fire) begin
      seen_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire) begin
      prev_acc_r <= out_access_count[CHK_W-1:0];
      prev_hit_r <= out_hit_count[CHK_W-1:0];
    end
  end

  // a stalled result beat holds
  `SALC_ASSERT_NXT(a_out_hold, clk, rst_n, (out_valid && out_stall),
    (out_valid && $stable(out_hit) && $stable(out_set_index) && $stable(out_access_count) && $stable(out_hit_count) && $stable(out_miss_count)),
    "result beat changed while stalled")

  // every access is either a hit or a miss
  `SALC_ASSERT_IMP(a_count_sum, clk, rst_n, out_fire,
    (CHK_W'(out_hit_count[CHK_W-1:0] + out_miss_count[CHK_W-1:0]) == out_access_count[CHK_W-1:0]),
    "hit and miss counts do not add up to the access count")

  // consecutive beats advance the counts by one access
  `SALC_ASSERT_IMP(a_count_step, clk, rst_n, (out_fire && seen_r),
    ((out_access_count[CHK_W-1:0] == CHK_W'(prev_acc_r + 1'b1)) && (out_hit_count[CHK_W-1:0] == CHK_W'(prev_hit_r + CHK_W'(out_hit)))),
    "counts did not advance by one beat")

  // one lookup at a time: an accepted address stalls the next cycle
  `SALC_ASSERT_NXT(a_in_busy, clk, rst_n, (in_valid && !in_stall), in_stall,
    "address accepted while a lookup was in progress")

  // reset empties the output register
  `SALC_ASSERT_NXT_RAW(a_reset_empty, clk, !rst_n, !out_valid,
    "result beat valid right after reset")

endmodule

bind set_assoc_lru_tag_cache_core salc_checker #(
  .COUNT_WIDTH (COUNT_WIDTH)
) u_salc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_hit          (out_hit),
  .out_set_index    (out_set_index),
  .out_access_count (out_access_count),
  .out_hit_count    (out_hit_count),
  .out_miss_count   (out_miss_count)
);

>>> tb/sv/set_assoc_lru_tag_cache_core_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result checker for the set-associative LRU tag lookup core
// Follows register writes and accepted address beats, keeps a model of the
// tag and valid store with its recency order, and compares every result
// beat with the oldest predicted lookup.
// ----------------------------------------------------------------------------
module set_assoc_lru_tag_cache_core_checker
  import salc_pkg::*;
#(
  parameter int MAX_INDEX_BITS = 8,
  parameter int MAX_WAYS       = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [ADDR_W-1:0]     in_address,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic                  out_hit,
  input  logic [SET_OUT_W-1:0]  out_set_index,
  input  logic [OUT_CNT_W-1:0]  out_access_count,
  input  logic [OUT_CNT_W-1:0]  out_hit_count,
  input  logic [OUT_CNT_W-1:0]  out_miss_count,
  output int                    mismatches,
  output int                    pending
);

  localparam int SETS = 1 << MAX_INDEX_BITS;

  typedef struct packed {
    logic                 hit;
    logic [SET_OUT_W-1:0] set_index;
    logic [OUT_CNT_W-1:0] access_count;
    logic [OUT_CNT_W-1:0] hit_count;
    logic [OUT_CNT_W-1:0] miss_count;
  } lookup_result_t;

  lookup_result_t lookups_due [$];

  // Tag store in recency order: way position 0 is LRU
  logic [TAG_W-1:0]      tag_store   [SETS][MAX_WAYS];
  bit                    valid_store [SETS][MAX_WAYS];
  logic [IB_W-1:0]       index_bits_reg;
  logic [BW_W-1:0]       block_log2_reg;
  logic [WAYS_CFG_W-1:0] ways_reg;
  logic [OUT_CNT_W-1:0]  access_total;
  logic [OUT_CNT_W-1:0]  hit_total;
  logic [OUT_CNT_W-1:0]  miss_total;

  // Look one address up, update recency order and counts, return the result
  function automatic lookup_result_t predict_lookup(input logic [ADDR_W-1:0] addr);
    lookup_result_t   res;
    int               ib;
    int               ob;
    int               ways;
    int               set_sel;
    int               pos;
    int               i;
    bit               found;
    logic [ADDR_W-1:0] shifted;
    logic [TAG_W-1:0] tag;
    ib      = (index_bits_reg > MAX_INDEX_BITS) ? MAX_INDEX_BITS : int'(index_bits_reg);
    ob      = ((block_log2_reg > MAX_BLK_LOG2) ? MAX_BLK_LOG2 : int'(block_log2_reg))
              + BYTE_OFS_W;
    ways    = (ways_reg == 0) ? 1 : ((ways_reg > MAX_WAYS) ? MAX_WAYS : int'(ways_reg));
    shifted = addr >> ob;
    set_sel = int'(shifted & ((32'd1 << ib) - 32'd1));
    tag     = TAG_W'(shifted >> ib);
    found   = 1'b0;
    pos     = 0;
    for (i = 0; i < ways; i++) begin
      if (!found && valid_store[set_sel][i] && tag_store[set_sel][i] == tag) begin
        found = 1'b1;
        pos   = i;
      end
    end
    // Close the gap left by the hit way, or by the LRU way on a miss
    for (i = pos; i + 1 < ways; i++) begin
      tag_store[set_sel][i]   = tag_store[set_sel][i+1];
      valid_store[set_sel][i] = valid_store[set_sel][i+1];
    end
    tag_store[set_sel][ways-1]   = tag;
    valid_store[set_sel][ways-1] = 1'b1;
    if (found) hit_total = hit_total + 1'b1;
    else       miss_total = miss_total + 1'b1;
    access_total = access_total + 1'b1;
    res.hit          = found;
    res.set_index    = SET_OUT_W'(set_sel);
    res.access_count = access_total;
    res.hit_count    = hit_total;
    res.miss_count   = miss_total;
    return res;
  endfunction

  task automatic check_field(input string field, input logic [OUT_CNT_W-1:0] want,
                             input logic [OUT_CNT_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, field, want, got);
    end
  endtask

  always @(posedge clk) begin : track
    lookup_result_t want;
    if (!rst_n) begin
      lookups_due.delete();
      foreach (valid_store[s, w]) begin
        valid_store[s][w] = 1'b0;
        tag_store[s][w]   = '0;
      end
      index_bits_reg = RST_INDEX_BITS;
      block_log2_reg = RST_BLOCK_LOG2;
      ways_reg       = RST_WAYS_IN_USE;
      access_total   = '0;
      hit_total      = '0;
      miss_total     = '0;
    end else begin
      // Compare a result beat with the oldest lookup still due
      if (out_valid && !out_stall) begin
        if (lookups_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result beat with no lookup outstanding", $realtime);
        end else begin
          want = lookups_due.pop_front();
          check_field("hit", OUT_CNT_W'(want.hit), OUT_CNT_W'(out_hit));
          check_field("set_index", OUT_CNT_W'(want.set_index), OUT_CNT_W'(out_set_index));
          check_field("access_count", want.access_count, out_access_count);
          check_field("hit_count", want.hit_count, out_hit_count);
          check_field("miss_count", want.miss_count, out_miss_count);
        end
      end
      // Follow register writes; unknown indexes drop
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_INDEX_BITS:  index_bits_reg = cfg_data;
          REG_BLOCK_LOG2:  block_log2_reg = cfg_data[BW_W-1:0];
          REG_WAYS_IN_USE: ways_reg       = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        lookups_due.push_back(predict_lookup(in_address));
    end
    pending = lookups_due.size();
  end

endmodule

>>> tb/sv/set_assoc_lru_tag_cache_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the set-associative LRU tag lookup core
// Drives address beats under a series of geometries (set count, block size,
// ways), first directed then random over small tag pools so that sets fill,
// hit and evict, with sender gaps and receiver stalls in several mixes.
// ----------------------------------------------------------------------------
module set_assoc_lru_tag_cache_core_tb;
  import salc_pkg::*;

  localparam int MAX_INDEX_BITS  = 8;
  localparam int MAX_WAYS        = 8;
  localparam int COUNT_WIDTH     = 32;
  localparam int RANDOM_PHASES   = 12;
  localparam int ITEMS_PER_PHASE = 58;
  localparam int POOL_SIZE       = 12;

  // Register index that the core does not decode
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum int {
    TRAFFIC_FREE,
    TRAFFIC_SENDER_GAPS,
    TRAFFIC_RECEIVER_STALLS,
    TRAFFIC_BOTH
  } traffic_mode_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = REG_INDEX_BITS;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  logic                  in_valid   = 1'b0;
  logic [ADDR_W-1:0]     in_address = '0;
  logic                  out_stall  = 1'b0;
  logic                  in_stall;
  logic                  out_valid;
  logic                  out_hit;
  logic [SET_OUT_W-1:0]  out_set_index;
  logic [OUT_CNT_W-1:0]  out_access_count;
  logic [OUT_CNT_W-1:0]  out_hit_count;
  logic [OUT_CNT_W-1:0]  out_miss_count;
  int                    mismatches;
  int                    pending;

  int          send_gap_pct = 0;
  int          stall_pct    = 0;
  int          cur_ib       = 4;
  int          cur_ob       = 2;
  int          cur_ways     = 1;
  logic [31:0] tag_pool [POOL_SIZE];

  // Index bits, block log2, ways: extremes, saturating codes and zero ways
  int phase_cfg [RANDOM_PHASES][3] = '{
    '{0, 0, 1}, '{8, 4, 8}, '{2, 1, 4}, '{3, 2, 0}, '{1, 3, 8}, '{5, 0, 2},
    '{0, 4, 8}, '{4, 2, 3}, '{6, 1, 5}, '{8, 0, 7}, '{7, 3, 6}, '{12, 6, 0}
  };

  // Under reset geometry: 16 sets, one way, one-word blocks
  logic [31:0] reset_geom_addrs [10] = '{
    32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0003,
    32'h0000_0040, 32'h0000_0000, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA
  };

  set_assoc_lru_tag_cache_core #(
    .MAX_INDEX_BITS (MAX_INDEX_BITS),
    .MAX_WAYS       (MAX_WAYS),
    .COUNT_WIDTH    (COUNT_WIDTH)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_address       (in_address),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_hit          (out_hit),
    .out_set_index    (out_set_index),
    .out_access_count (out_access_count),
    .out_hit_count    (out_hit_count),
    .out_miss_count   (out_miss_count)
  );

  set_assoc_lru_tag_cache_core_checker #(
    .MAX_INDEX_BITS (MAX_INDEX_BITS),
    .MAX_WAYS       (MAX_WAYS)
  ) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_address       (in_address),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_hit          (out_hit),
    .out_set_index    (out_set_index),
    .out_access_count (out_access_count),
    .out_hit_count    (out_hit_count),
    .out_miss_count   (out_miss_count),
    .mismatches       (mismatches),
    .pending          (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Stall the result channel at the current rate
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Bound the run in case the core hangs
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic set_traffic(input traffic_mode_t mode);
    send_gap_pct = (mode == TRAFFIC_SENDER_GAPS) ? 63 : (mode == TRAFFIC_BOTH) ? 27 : 0;
    stall_pct    = (mode == TRAFFIC_RECEIVER_STALLS) ? 63 : (mode == TRAFFIC_BOTH) ? 27 : 0;
  endtask

  // Offer one address beat and hold it until accepted; returns at a falling edge
  task automatic send_address(input logic [ADDR_W-1:0] addr);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_address <= addr;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Drop valid and wait for every outstanding result, then settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  // Write all three registers and track the geometry for address building
  task automatic configure(input int ib, input int bw, input int ways);
    write_reg(REG_INDEX_BITS, CFG_DATA_W'(ib));
    write_reg(REG_BLOCK_LOG2, CFG_DATA_W'(bw));
    write_reg(REG_WAYS_IN_USE, CFG_DATA_W'(ways));
    cfg_wr_en <= 1'b0;
    cur_ib   = (ib > MAX_INDEX_BITS) ? MAX_INDEX_BITS : ib;
    cur_ob   = ((bw > MAX_BLK_LOG2) ? MAX_BLK_LOG2 : bw) + BYTE_OFS_W;
    cur_ways = (ways == 0) ? 1 : ((ways > MAX_WAYS) ? MAX_WAYS : ways);
    foreach (tag_pool[k]) tag_pool[k] = $urandom();
  endtask

  // Mostly a few hot sets and a small tag pool, so sets fill, hit and evict
  function automatic logic [ADDR_W-1:0] pick_address();
    logic [ADDR_W-1:0] addr;
    int                set_max;
    int                set_sel;
    set_max = (1 << cur_ib) - 1;
    if ($urandom_range(99) < 15) return $urandom();
    if ($urandom_range(9) == 0 || set_max < 3) set_sel = $urandom_range(set_max);
    else set_sel = $urandom_range(3);
    addr = tag_pool[$urandom_range(cur_ways + 2)] << (cur_ib + cur_ob);
    addr = addr | (32'(set_sel) << cur_ob) | ($urandom() & ((32'd1 << cur_ob) - 32'd1));
    return addr;
  endfunction

  initial begin
    set_traffic(TRAFFIC_FREE);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait out the clearing pass
    repeat (2) @(posedge clk);
    do @(posedge clk); while (in_stall);
    @(negedge clk);

    // Reset geometry: hits, offset within a block, conflict eviction
    foreach (reset_geom_addrs[k]) send_address(reset_geom_addrs[k]);
    drain();

    // Undecoded register, then saturating codes: 256 sets, 16-word blocks, 8 ways
    write_reg(REG_UNUSED, 4'hF);
    configure(15, 7, 15);
    for (int t = 1; t <= 9; t++) send_address(32'(t) << 14);
    send_address(32'(2) << 14);
    send_address(32'(9) << 14);
    send_address(32'(1) << 14);
    send_address(32'hFFFF_FFFF);
    send_address(32'hFFFF_FFFF);
    send_address(32'h0000_0000);

    // Random phases; the store is kept across reconfiguration
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      configure(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2]);
      set_traffic(traffic_mode_t'(p % 4));
      repeat (ITEMS_PER_PHASE) send_address(pick_address());
    end
    drain();

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
